// ===== design/atan2pa_pkg.sv =====
`timescale 1ns / 1ps
// atan2pa_pkg: shared types, fixed-point formats and constants of the atan2 pipeline
// depends on nothing; used by every module of the block

package atan2pa_pkg;

    // slope is unsigned q1.15, 0..32768
    localparam int FRAC_Q  = 15;
    localparam int SLOPE_W = FRAC_Q + 1;

    // horner accumulator, signed, with headroom above q1.15
    localparam int ACC_W   = 18;
    localparam int PROD_W  = ACC_W + SLOPE_W + 1;
    localparam int RND_W   = PROD_W - FRAC_Q;

    // wide working width for the angle before it is cut to the output width
    localparam int EXT_W   = ACC_W + 16;

    localparam int HORNER_STEPS = 5;

    // polynomial coefficients, signed q1.15
    localparam logic signed [ACC_W-1:0] COEF_A = -ACC_W'(1647);
    localparam logic signed [ACC_W-1:0] COEF_B = ACC_W'(8717);
    localparam logic signed [ACC_W-1:0] COEF_C = -ACC_W'(14829);
    localparam logic signed [ACC_W-1:0] COEF_D = ACC_W'(782);
    localparam logic signed [ACC_W-1:0] COEF_E = ACC_W'(32714);

    // pi with 32 fraction bits
    localparam logic [63:0] PI_Q32 = 64'd13493037705;

    // sign and octant information that rides along with each beat
    typedef struct packed {
        logic x_neg;
        logic x_zero;
        logic y_neg;
        logic y_zero;
        logic big_x;
        logic origin;
    } oct_flags_t;

    // coefficient added after horner step idx; the last step adds nothing
    function automatic logic signed [ACC_W-1:0] coef_tail(input int idx);
        logic signed [ACC_W-1:0] c;
        case (idx)
            0:       c = COEF_B;
            1:       c = COEF_C;
            2:       c = COEF_D;
            3:       c = COEF_E;
            default: c = '0;
        endcase
        return c;
    endfunction

    // pi rounded to nearest at afb fraction bits
    function automatic logic [63:0] pi_at(input int afb);
        return (PI_Q32 + (64'd1 << (31 - afb))) >> (32 - afb);
    endfunction

    // pi/2 rounded to nearest at afb fraction bits
    function automatic logic [63:0] half_pi_at(input int afb);
        return (PI_Q32 + (64'd1 << (32 - afb))) >> (33 - afb);
    endfunction

endpackage

// ===== design/atan2_poly_approx.sv =====
`timescale 1ns / 1ps
// atan2_poly_approx: four-quadrant arctangent, fifth-order polynomial, fully pipelined
// depends on atan2pa_pkg, atan2pa_div_stage, atan2pa_horner_step, atan2pa_octant
//
// throughput: one beat per cycle; the 30-stage pipeline moves as one while the skid is empty
// the depth is set by the 16-stage slope divider (one bit per stage) and five horner steps
// reset clears every valid bit, including those of the output register and the skid; payload is not reset

module atan2_poly_approx #(
    parameter int  COORD_WIDTH     = 16,
    parameter int  ANGLE_FRAC_BITS = 13,
    localparam int OUT_W           = ANGLE_FRAC_BITS + 3,
    localparam int IN_TDATA_W      = ((2 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W     = ((OUT_W + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // x_coord, y_coord, zero pad
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // angle_rad, zero pad
);

    localparam int CW = COORD_WIDTH;
    localparam int SW = atan2pa_pkg::SLOPE_W;
    localparam int NH = atan2pa_pkg::HORNER_STEPS;

    // whole pipeline advances while the skid is empty
    logic en;

    // stage 1: magnitudes and signs
    logic [CW-1:0] x_in;
    logic [CW-1:0] y_in;
    logic [CW-1:0] ax_next;
    logic [CW-1:0] ay_next;
    logic          st1_valid_reg;
    logic [CW-1:0] st1_ax_reg;
    logic [CW-1:0] st1_ay_reg;
    logic          st1_xneg_reg;
    logic          st1_yneg_reg;
    logic          st1_xzero_reg;
    logic          st1_yzero_reg;

    // stage 2: pick dividend and divisor
    logic                    big_x_next;
    logic [CW-1:0]           small_next;
    logic [CW-1:0]           big_next;
    atan2pa_pkg::oct_flags_t flags_next;
    logic                    st2_valid_reg;
    logic [CW-1:0]           st2_rem_reg;
    logic                    st2_bit_reg;
    logic [CW-1:0]           st2_big_reg;
    atan2pa_pkg::oct_flags_t st2_flags_reg;

    // divider chain, one slot per stage boundary
    logic                    d_valid [SW+1];
    logic [CW-1:0]           d_rem   [SW+1];
    logic [CW-1:0]           d_big   [SW+1];
    logic [SW-1:0]           d_quo   [SW+1];
    atan2pa_pkg::oct_flags_t d_flags [SW+1];

    // horner chain
    logic                                  h_valid [NH+1];
    logic signed [atan2pa_pkg::ACC_W-1:0]  h_acc   [NH+1];
    logic [SW-1:0]                         h_slope [NH+1];
    atan2pa_pkg::oct_flags_t               h_flags [NH+1];

    // last pipeline stage
    logic             oc_valid;
    logic [OUT_W-1:0] oc_angle;

    // output register and skid
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [OUT_W-1:0] out_angle_reg;
    logic [OUT_W-1:0] out_angle_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [OUT_W-1:0] skid_angle_reg;
    logic [OUT_W-1:0] skid_angle_next;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // ---------------------------------------------------------------- stage 1
    assign x_in = s_axis_tdata[CW-1:0];
    assign y_in = s_axis_tdata[2*CW-1:CW];

    // the most negative value maps onto 2^(CW-1), which still fits unsigned
    assign ax_next = x_in[CW-1] ? (~x_in + CW'(1)) : x_in;
    assign ay_next = y_in[CW-1] ? (~y_in + CW'(1)) : y_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            st1_valid_reg <= s_axis_tvalid;
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_ax_reg    <= ax_next;
            st1_ay_reg    <= ay_next;
            st1_xneg_reg  <= x_in[CW-1];
            st1_yneg_reg  <= y_in[CW-1];
            st1_xzero_reg <= (x_in == '0);
            st1_yzero_reg <= (y_in == '0);
        end
    end

    // ---------------------------------------------------------------- stage 2
    // equal magnitudes take the y-dominant octant, slope comes out as one
    always_comb
    begin
        big_x_next        = st1_ay_reg < st1_ax_reg;
        small_next        = big_x_next ? st1_ay_reg : st1_ax_reg;
        big_next          = big_x_next ? st1_ax_reg : st1_ay_reg;
        flags_next.x_neg  = st1_xneg_reg;
        flags_next.x_zero = st1_xzero_reg;
        flags_next.y_neg  = st1_yneg_reg;
        flags_next.y_zero = st1_yzero_reg;
        flags_next.big_x  = big_x_next;
        flags_next.origin = st1_xzero_reg && st1_yzero_reg;
    end

    // dividend is small * 2^15: the top part seeds the remainder, the low bit is
    // brought down by the first divider stage, zeros after that
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st2_rem_reg   <= small_next >> 1;
            st2_bit_reg   <= small_next[0];
            st2_big_reg   <= big_next;
            st2_flags_reg <= flags_next;
        end
    end

    // ---------------------------------------------------------------- slope divider
    assign d_valid[0] = st2_valid_reg;
    assign d_rem[0]   = st2_rem_reg;
    assign d_big[0]   = st2_big_reg;
    assign d_quo[0]   = '0;
    assign d_flags[0] = st2_flags_reg;

    generate
        for (genvar i = 0; i < SW; i++)
        begin : g_div
            atan2pa_div_stage #(
                .MAG_W (CW)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (d_valid[i]),
                .in_rem    (d_rem[i]),
                .in_bit    ((i == 0) ? st2_bit_reg : 1'b0),
                .in_big    (d_big[i]),
                .in_quo    (d_quo[i]),
                .in_flags  (d_flags[i]),
                .out_valid (d_valid[i+1]),
                .out_rem   (d_rem[i+1]),
                .out_big   (d_big[i+1]),
                .out_quo   (d_quo[i+1]),
                .out_flags (d_flags[i+1])
            );
        end
    endgenerate

    // ---------------------------------------------------------------- horner polynomial
    assign h_valid[0] = d_valid[SW];
    assign h_acc[0]   = atan2pa_pkg::COEF_A;
    assign h_slope[0] = d_quo[SW];
    assign h_flags[0] = d_flags[SW];

    generate
        for (genvar k = 0; k < NH; k++)
        begin : g_horner
            atan2pa_horner_step u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (h_valid[k]),
                .in_acc    (h_acc[k]),
                .in_slope  (h_slope[k]),
                .coef      (atan2pa_pkg::coef_tail(k)),
                .in_flags  (h_flags[k]),
                .out_valid (h_valid[k+1]),
                .out_acc   (h_acc[k+1]),
                .out_slope (h_slope[k+1]),
                .out_flags (h_flags[k+1])
            );
        end
    endgenerate

    // ---------------------------------------------------------------- octant and quadrant
    atan2pa_octant #(
        .AFB (ANGLE_FRAC_BITS),
        .OW  (OUT_W)
    ) u_octant (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h_valid[NH]),
        .in_r      (h_acc[NH]),
        .in_flags  (h_flags[NH]),
        .out_valid (oc_valid),
        .out_angle (oc_angle)
    );

    // ---------------------------------------------------------------- output and skid
    // a beat leaving the pipeline goes to the output register when that is free or
    // being taken, otherwise into the skid, which then holds the pipeline
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_angle_next  = out_angle_reg;
        skid_valid_next = skid_valid_reg;
        skid_angle_next = skid_angle_reg;
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_angle_next  = skid_angle_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (oc_valid)
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                out_valid_next = 1'b1;
                out_angle_next = oc_angle;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_angle_next = oc_angle;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_angle_reg  <= out_angle_next;
        skid_angle_reg <= skid_angle_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_angle_reg);

    // ---------------------------------------------------------------- checks
    localparam logic signed [OUT_W-1:0] PI_OUT = OUT_W'(atan2pa_pkg::pi_at(ANGLE_FRAC_BITS));

    // the skid only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid filled although the output beat was free to go");

    // slope from the divider never exceeds one in q1.15
    a_slope_range: assert property (@(posedge clk) disable iff (!rst_n)
        (h_valid[0] && !h_flags[0].origin) |-> (h_slope[0] <= (SW'(1) << (SW - 1))))
        else $error("divider slope above one");

    // every delivered angle lies within -pi..+pi
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(out_angle_reg) <= PI_OUT
                           && $signed(out_angle_reg) >= -PI_OUT))
        else $error("output angle outside -pi..+pi");

endmodule

// ===== design/atan2pa_div_stage.sv =====
`timescale 1ns / 1ps
// atan2pa_div_stage: one registered restoring-division step, one slope bit per stage
// depends on atan2pa_pkg

module atan2pa_div_stage #(
    parameter int MAG_W = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [MAG_W-1:0]                   in_rem,
    input  logic                               in_bit,
    input  logic [MAG_W-1:0]                   in_big,
    input  logic [atan2pa_pkg::SLOPE_W-1:0]    in_quo,
    input  atan2pa_pkg::oct_flags_t            in_flags,
    output logic                               out_valid,
    output logic [MAG_W-1:0]                   out_rem,
    output logic [MAG_W-1:0]                   out_big,
    output logic [atan2pa_pkg::SLOPE_W-1:0]    out_quo,
    output atan2pa_pkg::oct_flags_t            out_flags
);

    logic                            valid_reg;
    logic [MAG_W-1:0]                rem_reg;
    logic [MAG_W-1:0]                big_reg;
    logic [atan2pa_pkg::SLOPE_W-1:0] quo_reg;
    atan2pa_pkg::oct_flags_t         flags_reg;

    logic [MAG_W:0]                  trial;
    logic                            fits;
    logic [MAG_W-1:0]                rem_next;
    logic [atan2pa_pkg::SLOPE_W-1:0] quo_next;

    // bring down one dividend bit, subtract the divisor where it fits
    always_comb
    begin
        trial    = {in_rem, in_bit};
        fits     = trial >= {1'b0, in_big};
        rem_next = fits ? MAG_W'(trial - {1'b0, in_big}) : MAG_W'(trial);
        quo_next = {in_quo[atan2pa_pkg::SLOPE_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg   <= rem_next;
            big_reg   <= in_big;
            quo_reg   <= quo_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_big   = big_reg;
    assign out_quo   = quo_reg;
    assign out_flags = flags_reg;

endmodule

// ===== design/atan2pa_horner_step.sv =====
`timescale 1ns / 1ps
// atan2pa_horner_step: one horner step in two stages, multiply then round and add
// depends on atan2pa_pkg

module atan2pa_horner_step (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic signed [atan2pa_pkg::ACC_W-1:0]    in_acc,
    input  logic [atan2pa_pkg::SLOPE_W-1:0]         in_slope,
    input  logic signed [atan2pa_pkg::ACC_W-1:0]    coef,
    input  atan2pa_pkg::oct_flags_t                 in_flags,
    output logic                                    out_valid,
    output logic signed [atan2pa_pkg::ACC_W-1:0]    out_acc,
    output logic [atan2pa_pkg::SLOPE_W-1:0]         out_slope,
    output atan2pa_pkg::oct_flags_t                 out_flags
);

    // product stage
    logic                                     mul_valid_reg;
    logic signed [atan2pa_pkg::PROD_W-1:0]    prod_reg;
    logic signed [atan2pa_pkg::PROD_W-1:0]    prod_next;
    logic [atan2pa_pkg::SLOPE_W-1:0]          mul_slope_reg;
    atan2pa_pkg::oct_flags_t                  mul_flags_reg;

    // round-and-add stage
    logic                                     add_valid_reg;
    logic signed [atan2pa_pkg::ACC_W-1:0]     acc_reg;
    logic signed [atan2pa_pkg::ACC_W-1:0]     acc_next;
    logic [atan2pa_pkg::SLOPE_W-1:0]          add_slope_reg;
    atan2pa_pkg::oct_flags_t                  add_flags_reg;

    logic signed [atan2pa_pkg::PROD_W-1:0]    rnd_sum;
    logic signed [atan2pa_pkg::RND_W-1:0]     rounded;
    logic signed [atan2pa_pkg::RND_W-1:0]     coef_ext;

    assign prod_next = in_acc * $signed({1'b0, in_slope});

    // round half up back to q1.15, then add the next coefficient
    always_comb
    begin
        rnd_sum  = prod_reg + $signed({{(atan2pa_pkg::PROD_W - atan2pa_pkg::FRAC_Q){1'b0}},
                                       1'b1, {(atan2pa_pkg::FRAC_Q - 1){1'b0}}});
        rounded  = rnd_sum[atan2pa_pkg::PROD_W-1:atan2pa_pkg::FRAC_Q];
        coef_ext = atan2pa_pkg::RND_W'(coef);
        acc_next = atan2pa_pkg::ACC_W'(rounded + coef_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= in_valid;
            add_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg      <= prod_next;
            mul_slope_reg <= in_slope;
            mul_flags_reg <= in_flags;
            acc_reg       <= acc_next;
            add_slope_reg <= mul_slope_reg;
            add_flags_reg <= mul_flags_reg;
        end
    end

    assign out_valid = add_valid_reg;
    assign out_acc   = acc_reg;
    assign out_slope = add_slope_reg;
    assign out_flags = add_flags_reg;

endmodule

// ===== design/atan2pa_octant.sv =====
`timescale 1ns / 1ps
// atan2pa_octant: scales the octant angle and folds it into the full circle
// depends on atan2pa_pkg

module atan2pa_octant #(
    parameter int AFB = 13,
    parameter int OW  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [atan2pa_pkg::ACC_W-1:0]  in_r,
    input  atan2pa_pkg::oct_flags_t               in_flags,
    output logic                                  out_valid,
    output logic [OW-1:0]                         out_angle
);

    localparam int EW = atan2pa_pkg::EXT_W;
    localparam logic signed [EW-1:0] PI_V      = EW'(atan2pa_pkg::pi_at(AFB));
    localparam logic signed [EW-1:0] HALF_PI_V = EW'(atan2pa_pkg::half_pi_at(AFB));

    logic                     scl_valid_reg;
    logic signed [EW-1:0]     r_reg;
    logic signed [EW-1:0]     r_next;
    logic signed [EW-1:0]     r_wide;
    atan2pa_pkg::oct_flags_t  scl_flags_reg;

    logic                     ang_valid_reg;
    logic [OW-1:0]            ang_reg;
    logic [OW-1:0]            ang_next;
    logic signed [EW-1:0]     ang_wide;
    logic                     x_pos;
    logic                     y_pos;

    assign r_wide = EW'(in_r);

    // q1.15 to AFB fraction bits
    generate
        if (AFB >= atan2pa_pkg::FRAC_Q)
        begin : g_up
            localparam int UP = AFB - atan2pa_pkg::FRAC_Q;
            assign r_next = r_wide <<< UP;
        end
        else
        begin : g_down
            localparam int DN = atan2pa_pkg::FRAC_Q - AFB;
            localparam logic signed [EW-1:0] HALF_LSB = EW'(64'd1 << (DN - 1));
            assign r_next = (r_wide + HALF_LSB) >>> DN;
        end
    endgenerate

    always_comb
    begin
        x_pos = !scl_flags_reg.x_neg && !scl_flags_reg.x_zero;
        y_pos = !scl_flags_reg.y_neg && !scl_flags_reg.y_zero;
        if (scl_flags_reg.origin)
        begin
            ang_wide = '0;
        end
        else if (scl_flags_reg.big_x)
        begin
            if (x_pos)
                ang_wide = scl_flags_reg.y_neg ? -r_reg : r_reg;
            else
                ang_wide = scl_flags_reg.y_neg ? r_reg - PI_V : PI_V - r_reg;
        end
        else
        begin
            if (!scl_flags_reg.x_neg)
                ang_wide = y_pos ? HALF_PI_V - r_reg : r_reg - HALF_PI_V;
            else
                ang_wide = y_pos ? r_reg + HALF_PI_V : -r_reg - HALF_PI_V;
        end
        ang_next = ang_wide[OW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_valid_reg <= 1'b0;
            ang_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            scl_valid_reg <= in_valid;
            ang_valid_reg <= scl_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg         <= r_next;
            scl_flags_reg <= in_flags;
            ang_reg       <= ang_next;
        end
    end

    assign out_valid = ang_valid_reg;
    assign out_angle = ang_reg;

endmodule
